>>> design/leb128_pkg.sv
// ----------------------------------------------------------------------------
// leb128_pkg
// Shared types, constants and format helpers for the LEB128 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package leb128_pkg;

    // Encoded byte layout
    localparam int LEB_BYTE_W   = 8;
    localparam int LEB_DIGIT_W  = 7;
    localparam int LEB_CONT_BIT = 7;
    localparam int LEB_SIGN_BIT = 6;

    // Value and count widths
    localparam int LEB_ACC_W   = 64;
    localparam int LEB_CNT_W   = 4;
    localparam int LEB_FUNC_W  = 3;

    // Stream widths: tdata holds value then byte count, padded to bytes
    localparam int LEB_OUT_PAYLOAD_W = LEB_ACC_W + LEB_CNT_W;
    localparam int LEB_OUT_TDATA_W   = ((LEB_OUT_PAYLOAD_W + 7) / 8) * 8;

    // Format selector codes; unused codes decode as signed 64 bit
    typedef enum logic [LEB_FUNC_W-1:0] {
        FMT_U1  = 3'd0,
        FMT_U7  = 3'd1,
        FMT_U32 = 3'd2,
        FMT_S7  = 3'd3,
        FMT_S32 = 3'd4,
        FMT_S64 = 3'd5
    } t_fmt;

    // One accepted input byte
    typedef struct packed {
        logic [LEB_BYTE_W-1:0] data_byte;
        logic [LEB_FUNC_W-1:0] func;
    } t_leb_item;

    // Result of one byte step
    typedef struct packed {
        logic                 valid;
        logic [LEB_ACC_W-1:0] decoded_value;
        logic                 overlong;
        logic [LEB_CNT_W-1:0] bytes_used;
    } t_leb_result;

    // Byte limit of a format
    function automatic logic [LEB_CNT_W:0] fmt_limit(input logic [LEB_FUNC_W-1:0] f);
        logic [LEB_CNT_W:0] lim;
        case (f)
            FMT_U1, FMT_U7, FMT_S7: lim = 5'd1;
            FMT_U32, FMT_S32:       lim = 5'd5;
            default:                lim = 5'd10;
        endcase
        return lim;
    endfunction

    // Signed formats
    function automatic logic fmt_signed(input logic [LEB_FUNC_W-1:0] f);
        return (f >= FMT_S7);
    endfunction

    // Truncate to the container and re-extend to 64 bits
    function automatic logic [LEB_ACC_W-1:0] fmt_fit(input logic [LEB_ACC_W-1:0] v,
                                                      input logic [LEB_FUNC_W-1:0] f);
        logic                 s;
        logic [LEB_ACC_W-1:0] r;
        s = fmt_signed(f);
        case (f)
            FMT_U1, FMT_U7, FMT_S7: begin
                r = {{56{s & v[7]}}, v[7:0]};
            end
            FMT_U32, FMT_S32: begin
                r = {{32{s & v[31]}}, v[31:0]};
            end
            default: begin
                r = v;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/leb128_stream_decoder.sv
// ----------------------------------------------------------------------------
// leb128_stream_decoder
// Byte-serial LEB128 decoder with selectable format.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one encoded byte per transfer on s_axis_tdata with the
//   format code on s_axis_tuser (0 u1, 1 u7, 2 u32, 3 s7, 4 s32, 5 s64;
//   other codes act as s64). The code must stay the same within one value.
//   Master side gives one transfer per finished value: decoded value and
//   byte count on m_axis_tdata, the overlong flag on m_axis_tuser.
//   A value's last byte is taken into the input register at its transfer,
//   then decoded and loaded into the result register, which drives the
//   master side; a stalled receiver can hold back that load.
//   Throughput: one byte per cycle unless a finished value waits on a stalled
//   receiver, set by the single decode step between the two registers.
//   Reset clears the accumulator, the byte count and both valid flags.
//   When the receiver stalls, the result is held; the input register keeps
//   filling with continuation bytes, and only a byte that ends a value waits,
//   after which s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module leb128_stream_decoder import leb128_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Slave side
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [LEB_BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  wire logic [LEB_FUNC_W-1:0]      s_axis_tuser,   // [2:0] func
    // Master side
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [LEB_OUT_TDATA_W-1:0]      m_axis_tdata,   // [63:0] decoded_value,
                                                             // [67:64] bytes_used
    output logic                            m_axis_tuser    // [0] overlong
);

    t_leb_item   in_item;
    t_leb_item   held_item;
    logic        held_valid;
    logic        fire;
    logic        out_busy;
    t_leb_result step_res;
    t_leb_result out_res;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.func      = s_axis_tuser;

    // Input register
    leb128_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .i_item    (in_item),
        .i_advance (fire),
        .o_tready  (s_axis_tready),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // Decode step; a byte that yields a result waits for room
    assign fire = held_valid && (!step_res.valid || !out_busy);

    leb128_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (step_res)
    );

    // Result register
    leb128_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && step_res.valid),
        .i_result (step_res),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_busy   (out_busy),
        .o_result (out_res)
    );

    assign m_axis_tdata = {{(LEB_OUT_TDATA_W-LEB_OUT_PAYLOAD_W){1'b0}},
                           out_res.bytes_used, out_res.decoded_value};
    assign m_axis_tuser = out_res.overlong;

endmodule

`default_nettype wire

>>> design/leb128_in_stage.sv
// ----------------------------------------------------------------------------
// leb128_in_stage
// Input register: captures one byte transfer and holds it until the core
// consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module leb128_in_stage import leb128_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_tvalid,
    input  wire t_leb_item i_item,
    input  wire logic      i_advance,   // core consumes the held item
    output logic           o_tready,
    output logic           o_valid,
    output t_leb_item      o_item
);

    logic      r_valid, n_valid;
    t_leb_item r_item;

    // Free, or emptying this cycle
    assign o_tready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_tvalid && o_tready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> design/leb128_core.sv
// ----------------------------------------------------------------------------
// leb128_core
// Accumulator and byte count, with the single-byte decode step: merge the
// seven payload bits, check the byte limit, sign-extend and fit on the last
// byte.
// ----------------------------------------------------------------------------
`default_nettype none

module leb128_core import leb128_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,      // held item is consumed this cycle
    input  wire t_leb_item i_item,
    output t_leb_result    o_result
);

    logic [LEB_ACC_W-1:0] r_acc, n_acc;
    logic [LEB_CNT_W-1:0] r_cnt, n_cnt;

    logic [LEB_DIGIT_W-1:0] payload;
    logic [6:0]             shamt;
    logic [7:0]             ext_sh;
    logic [LEB_CNT_W:0]     newcnt;
    logic [LEB_CNT_W:0]     limit;
    logic                   more;
    logic                   too_long;
    logic [LEB_ACC_W-1:0]   acc_or;
    logic [LEB_ACC_W-1:0]   ext_v;

    assign payload = i_item.data_byte[LEB_DIGIT_W-1:0];
    assign more    = i_item.data_byte[LEB_CONT_BIT];
    // 7 * count as shift-and-subtract
    assign shamt   = {r_cnt, 3'b000} - {3'b000, r_cnt};
    assign newcnt  = {1'b0, r_cnt} + 5'd1;
    assign ext_sh  = {newcnt, 3'b000} - {3'b000, newcnt};
    assign limit   = fmt_limit(i_item.func);

    // Merge payload at the next digit position
    always_comb begin
        acc_or = r_acc;
        if (shamt < 7'd64) begin
            acc_or = r_acc | ({{(LEB_ACC_W-LEB_DIGIT_W){1'b0}}, payload} << shamt[5:0]);
        end
    end

    // Byte limit reached with more to come, or passed
    assign too_long = (newcnt > limit) || (more && (newcnt >= limit));

    // Sign extension above the gathered bits, then fit to the container
    always_comb begin
        ext_v = acc_or;
        if (fmt_signed(i_item.func) && (ext_sh < 8'd64) &&
            i_item.data_byte[LEB_SIGN_BIT]) begin
            ext_v = acc_or | ({LEB_ACC_W{1'b1}} << ext_sh[5:0]);
        end
    end

    always_comb begin
        o_result.valid         = too_long || !more;
        o_result.overlong      = too_long;
        o_result.bytes_used    = newcnt[LEB_CNT_W-1:0];
        o_result.decoded_value = too_long ? '0 : fmt_fit(ext_v, i_item.func);
    end

    // Next state: clear at end of value, else keep gathering
    always_comb begin
        if (too_long || !more) begin
            n_acc = '0;
            n_cnt = '0;
        end else begin
            n_acc = acc_or;
            n_cnt = newcnt[LEB_CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_fire) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> design/leb128_out_stage.sv
// ----------------------------------------------------------------------------
// leb128_out_stage
// Result register: holds one decoded value until the receiver takes the
// transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module leb128_out_stage import leb128_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_leb_result i_result,
    input  wire logic        i_tready,
    output logic             o_tvalid,
    output logic             o_busy,     // holds a result the receiver refuses
    output t_leb_result      o_result
);

    logic        r_valid, n_valid;
    t_leb_result r_result;

    assign o_busy = r_valid && !i_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> design/leb128_checker.sv
// ----------------------------------------------------------------------------
// leb128_checker
// Port-level checks for the LEB128 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module leb128_checker import leb128_pkg::*; (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [LEB_OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                       m_axis_tuser
);

    // Held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An overlong value carries a zero value
    a_overlong_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[LEB_ACC_W-1:0] == '0))
        else $error("overlong result with nonzero value");

    // Byte count of a result lies in 1..10
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[LEB_OUT_PAYLOAD_W-1:LEB_ACC_W] != 4'd0) &&
            (m_axis_tdata[LEB_OUT_PAYLOAD_W-1:LEB_ACC_W] <= 4'd10))
        else $error("bytes_used out of range");

    // Input only backs up behind a refused result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no result waiting");

    // Nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind leb128_stream_decoder leb128_checker u_leb128_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> dv/leb128_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb128_stream_decoder_tb
// Self-checking bench for the byte-serial LEB128 decoder.
// ----------------------------------------------------------------------------
// A short directed run covers format edges (all but s32), then random values
// follow: most of them well formed, some overlong, some with the selector
// switched part-way through, and some plain noise. Every accepted byte goes
// through a local decoder model, and each result transfer is checked field by
// field against the oldest pending prediction. Both sides idle at random in
// the first two of three phases. The receiver also holds off once for a long
// stretch, and the sender stops a few times until all pending results return.
// ----------------------------------------------------------------------------

module leb128_stream_decoder_tb;
    import leb128_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_BYTES = 1100;
    localparam int unsigned SETTLE       = 10;

    // One byte waiting to be sent; drain makes the sender wait for all results
    typedef struct {
        logic [LEB_BYTE_W-1:0] data_byte;
        logic [LEB_FUNC_W-1:0] func;
        bit                    drain;
    } t_pending;

    // One decoded value as the block should report it
    typedef struct packed {
        logic [LEB_ACC_W-1:0] value;
        logic                 overlong;
        logic [LEB_CNT_W-1:0] bytes_used;
    } t_decoded;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [LEB_BYTE_W-1:0]      s_axis_tdata  = '0;   // [7:0] data_byte
    logic [LEB_FUNC_W-1:0]      s_axis_tuser  = '0;   // [2:0] func
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [LEB_OUT_TDATA_W-1:0] m_axis_tdata;         // [63:0] value, [67:64] bytes_used
    logic                       m_axis_tuser;         // [0] overlong

    // Decoder model state
    logic [LEB_ACC_W-1:0] gathered_bits = '0;
    logic [LEB_CNT_W-1:0] bytes_so_far  = '0;

    t_pending    byte_queue[$];
    t_decoded    decoded_q[$];
    int unsigned total_bytes      = 0;
    int unsigned bytes_accepted   = 0;
    int unsigned values_predicted = 0;
    int unsigned values_seen      = 0;
    int unsigned overlong_seen    = 0;
    int unsigned err_count        = 0;
    int unsigned cycle_count      = 0;
    int unsigned hold_left        = 0;
    bit          hold_done        = 1'b0;

    leb128_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Model one byte; returns 1 when the byte finishes a value
    function automatic bit decode_byte(input logic [LEB_BYTE_W-1:0] b,
                                       input logic [LEB_FUNC_W-1:0] f,
                                       output t_decoded r);
        int unsigned          lim, width, pos, cnt;
        bit                   sgn, more;
        logic [LEB_ACC_W-1:0] v, keep;
        case (f)
            FMT_U1, FMT_U7, FMT_S7: begin
                lim   = 1;
                width = 8;
            end
            FMT_U32, FMT_S32: begin
                lim   = 5;
                width = 32;
            end
            default: begin
                lim   = 10;
                width = 64;
            end
        endcase
        sgn  = (f >= FMT_S7);
        more = b[LEB_CONT_BIT];
        pos  = LEB_DIGIT_W * bytes_so_far;
        cnt  = bytes_so_far + 1;
        if (pos < LEB_ACC_W)
            gathered_bits |= 64'(b[LEB_DIGIT_W-1:0]) << pos;
        r = '0;
        r.bytes_used = cnt[LEB_CNT_W-1:0];
        // too many bytes for the format: error, value dropped
        if (cnt > lim || (more && cnt >= lim)) begin
            r.overlong    = 1'b1;
            gathered_bits = '0;
            bytes_so_far  = '0;
            return 1'b1;
        end
        if (more) begin
            bytes_so_far = cnt[LEB_CNT_W-1:0];
            return 1'b0;
        end
        v = gathered_bits;
        if (sgn && LEB_DIGIT_W * cnt < LEB_ACC_W && b[LEB_SIGN_BIT])
            v |= {LEB_ACC_W{1'b1}} << (LEB_DIGIT_W * cnt);
        // cut to the container, then extend back to 64 bits
        if (width < LEB_ACC_W) begin
            keep = (64'd1 << width) - 64'd1;
            v &= keep;
            if (sgn && v[width-1])
                v |= ~keep;
        end
        r.value       = v;
        gathered_bits = '0;
        bytes_so_far  = '0;
        return 1'b1;
    endfunction

    // Idle phase from progress: sender light / receiver heavy, swapped, none
    function automatic int unsigned idle_phase();
        if (bytes_accepted < total_bytes / 3)
            return 0;
        if (bytes_accepted < (2 * total_bytes) / 3)
            return 1;
        return 2;
    endfunction

    function automatic void add_byte(input logic [LEB_BYTE_W-1:0] b,
                                     input logic [LEB_FUNC_W-1:0] f);
        t_pending p;
        p.data_byte = b;
        p.func      = f;
        p.drain     = 1'b0;
        byte_queue.push_back(p);
    endfunction

    // n bytes of random payload; the last one keeps its continuation bit if asked
    function automatic void add_value(input logic [LEB_FUNC_W-1:0] f,
                                      input int unsigned n, input bit last_cont);
        for (int unsigned i = 1; i < n; i++)
            add_byte({1'b1, 7'($urandom)}, f);
        add_byte({last_cont, 7'($urandom)}, f);
    endfunction

    function automatic int unsigned format_limit(input logic [LEB_FUNC_W-1:0] f);
        case (f)
            FMT_U1, FMT_U7, FMT_S7: return 1;
            FMT_U32, FMT_S32:       return 5;
            default:                return 10;
        endcase
    endfunction

    task automatic mismatch(input string what, input logic [63:0] got,
                            input logic [63:0] want);
        $display("ERROR %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Byte sender: records accepted transfers and offers the next byte
    always @(posedge i_clk) begin : byte_sender
        t_decoded    res;
        t_pending    nxt;
        bit          done;
        int unsigned waiting, gap_pct;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            done = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                done = decode_byte(s_axis_tdata, s_axis_tuser, res);
                if (done)
                    decoded_q.push_back(res);
                bytes_accepted <= bytes_accepted + 1;
            end
            values_predicted <= values_predicted + done;
            waiting = values_predicted + done - values_seen;
            case (idle_phase())
                0:       gap_pct = 20;
                1:       gap_pct = 65;
                default: gap_pct = 0;
            endcase
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_queue.size() != 0 && !(byte_queue[0].drain && waiting != 0)
                        && $urandom_range(0, 99) >= gap_pct) begin
                    nxt = byte_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data_byte;
                    s_axis_tuser  <= nxt.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: checks each transfer, drives tready with stalls
    always @(posedge i_clk) begin : result_checker
        t_decoded    want;
        int unsigned stall_pct;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                values_seen <= values_seen + 1;
                if (m_axis_tuser)
                    overlong_seen <= overlong_seen + 1;
                if (decoded_q.size() == 0) begin
                    mismatch("result with nothing pending", m_axis_tdata[63:0], '0);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_axis_tdata[63:0] !== want.value)
                        mismatch("decoded_value", m_axis_tdata[63:0], want.value);
                    if (m_axis_tuser !== want.overlong)
                        mismatch("overlong", 64'(m_axis_tuser), 64'(want.overlong));
                    if (m_axis_tdata[67:64] !== want.bytes_used)
                        mismatch("bytes_used", 64'(m_axis_tdata[67:64]),
                                 64'(want.bytes_used));
                end
            end
            case (idle_phase())
                0:       stall_pct = 65;
                1:       stall_pct = 20;
                default: stall_pct = 0;
            endcase
            // one long hold-off in the no-idle phase so the input backs up
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && bytes_accepted >= (2 * total_bytes) / 3 + 40) begin
                hold_left     <= HOLD_CYCLES;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** leb128_stream_decoder: FAILED **");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [LEB_FUNC_W-1:0] f, f2;
        int unsigned           lim, len, kind, first_len;
        // directed: format edges, errors, unused codes, selector switches
        add_byte(8'h00, FMT_U1);
        add_byte(8'h7f, FMT_U1);
        add_byte(8'h55, FMT_U7);
        add_byte(8'h40, FMT_S7);
        add_byte(8'h3f, FMT_S7);
        add_byte(8'h80, FMT_U1);
        repeat (5) add_byte(8'hff, FMT_U32);
        repeat (9) add_byte(8'hff, FMT_S64);
        add_byte(8'h7f, FMT_S64);
        add_byte(8'h7f, 3'(FMT_S64 + 1));
        add_byte(8'h01, 3'(FMT_S64 + 2));
        add_byte(8'h80, FMT_S64);
        add_byte(8'h01, FMT_U32);
        add_byte(8'h80, FMT_S64);
        add_byte(8'h00, FMT_U1);

        // random: mostly well-formed values of short length
        while (byte_queue.size() < RANDOM_BYTES + 25) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                f = 3'(FMT_S64 + 1 + $urandom_range(0, 1));
            else
                f = 3'($urandom_range(FMT_U1, FMT_S64));
            lim = format_limit(f);
            if (kind < 75) begin
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(1, lim);
                else
                    len = $urandom_range(1, lim < 3 ? lim : 3);
                add_value(f, len, 1'b0);
            end else if (kind < 85) begin
                add_value(f, lim, 1'b1);
            end else if (kind < 92) begin
                // switch selector part-way through a value
                first_len = $urandom_range(1, lim > 1 ? lim - 1 : 1);
                if (first_len < lim) begin
                    for (int unsigned i = 0; i < first_len; i++)
                        add_byte({1'b1, 7'($urandom)}, f);
                end
                f2 = 3'($urandom_range(0, (1 << LEB_FUNC_W) - 1));
                add_byte(8'($urandom), f2);
            end else begin
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom), 3'($urandom));
            end
        end
        // a few points where the sender waits until all results are back
        byte_queue[byte_queue.size() / 2].drain = 1'b1;
        repeat (3) byte_queue[$urandom_range(30, byte_queue.size() - 1)].drain = 1'b1;
        total_bytes = byte_queue.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_accepted != total_bytes || values_predicted != values_seen)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Decoded %0d bytes into %0d values, %0d of them overlong.",
                 bytes_accepted, values_seen, overlong_seen);
        $display("Covered all formats, unused selectors, mid-value switches and stalls.");
        if (err_count == 0) begin
            $display("** leb128_stream_decoder: PASSED **");
        end else begin
            $display("%0d mismatches", err_count);
            $display("** leb128_stream_decoder: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/leb128_pkg.sv
design/leb128_in_stage.sv
design/leb128_core.sv
design/leb128_out_stage.sv
design/leb128_stream_decoder.sv
design/leb128_checker.sv
dv/leb128_stream_decoder_tb.sv
